FILE: src/protobuf_wire_field_decoder_core_defines.svh
// assertion macros for the protobuf wire field decoder
`ifndef PROTOBUF_WIRE_FIELD_DECODER_CORE_DEFINES_SVH
`define PROTOBUF_WIRE_FIELD_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define PWFD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pwfd assertion failed");

// checked at every edge, reset included
`define PWFD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pwfd assertion failed");

`else

`define PWFD_ASSERT(name, clk, rst_n, prop)
`define PWFD_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

FILE: src/pwfd_pkg.sv
// types and constants of the protobuf wire field decoder
`timescale 1ns / 1ps

package pwfd_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int RES_DEPTH       = 4;

  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LEN     = 3'd2;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  typedef enum logic [1:0] {
    KIND_SCALAR  = 2'd0,
    KIND_LENGTH  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_VARINT_LONG = 3'd1,
    ERR_BAD_WIRE    = 3'd2,
    ERR_LEN_WIDE    = 3'd3,
    ERR_TRUNCATED   = 3'd4
  } err_e;

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_VARINT  = 7'b0000010,
    PH_FIXED32 = 7'b0000100,
    PH_FIXED64 = 7'b0001000,
    PH_LENGTH  = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_ERROR   = 7'b1000000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [63:0] acc;
    logic [3:0]  count;
    logic [31:0] cur_field;
    logic [2:0]  cur_wire;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] field_num;
    logic [2:0]  wire_kind;
    logic [63:0] value;
    logic        payload_last;
    err_e        error_code;
  } res_t;

endpackage

FILE: src/pwfd_if.sv
// request channels of the protobuf wire field decoder
`timescale 1ns / 1ps

interface pwfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface pwfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] field_num;
  logic [2:0]  wire_kind;
  logic [63:0] value;
  logic        payload_last;
  logic [2:0]  error_code;

  modport source (
    output valid, output kind, output field_num, output wire_kind,
    output value, output payload_last, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input field_num, input wire_kind,
    input value, input payload_last, input error_code, output ready
  );
endinterface

FILE: src/pwfd_step.sv
// next-state and result logic for one message byte
`timescale 1ns / 1ps

module pwfd_step #(
  parameter int LENGTH_BITS = pwfd_pkg::LENGTH_BITS_DEF
) (
  input  logic                   pass_i,
  input  logic [7:0]             byte_i,
  input  logic                   eob_i,
  input  pwfd_pkg::state_t       state_i,
  input  logic [LENGTH_BITS-1:0] rem_i,
  output pwfd_pkg::state_t       state_o,
  output logic [LENGTH_BITS-1:0] rem_o,
  output pwfd_pkg::res_t         res0_o,
  output pwfd_pkg::res_t         res1_o,
  output logic [1:0]             res_cnt_o
);

  localparam logic [63:0] LenMask =
    (LENGTH_BITS >= 64) ? '1 : ((64'd1 << LENGTH_BITS) - 64'd1);

  logic                   is_fixed;
  logic [6:0]             sh7;
  logic [5:0]             shamt;
  logic [63:0]            sh_data;
  logic [63:0]            acc_n;
  logic [3:0]             cnt_n;
  logic                   cont;
  logic                   too_long;
  logic                   fixed_done;
  logic [LENGTH_BITS-1:0] rem_n;
  logic                   emit_a;
  pwfd_pkg::kind_e        kind_a;
  logic [63:0]            val_a;
  logic                   last_a;
  logic                   fail;
  pwfd_pkg::err_e         code;
  logic                   to_hdr;
  logic                   bad_wire;

  // shared shift-or unit: 7 bits per varint byte, 8 bits per fixed byte
  always_comb begin
    is_fixed = (state_i.phase == pwfd_pkg::PH_FIXED32) ||
               (state_i.phase == pwfd_pkg::PH_FIXED64);
    sh7      = {state_i.count, 3'b000} - {3'b000, state_i.count};
    if (is_fixed) begin
      shamt   = {state_i.count[2:0], 3'b000};
      sh_data = {56'd0, byte_i};
    end else begin
      shamt   = sh7[5:0];
      sh_data = sh7[6] ? 64'd0 : {57'd0, byte_i[6:0]};
    end
    acc_n      = state_i.acc | (sh_data << shamt);
    cnt_n      = state_i.count + 4'd1;
    cont       = byte_i[7];
    too_long   = cont && (cnt_n >= 4'd10);
    fixed_done = (state_i.phase == pwfd_pkg::PH_FIXED32) ? (cnt_n >= 4'd4) : (cnt_n >= 4'd8);
    rem_n      = rem_i - LENGTH_BITS'(1);
    bad_wire   = (acc_n[2:0] != pwfd_pkg::WIRE_VARINT) &&
                 (acc_n[2:0] != pwfd_pkg::WIRE_FIXED64) &&
                 (acc_n[2:0] != pwfd_pkg::WIRE_LEN) &&
                 (acc_n[2:0] != pwfd_pkg::WIRE_FIXED32);
  end

  always_comb begin
    state_o = state_i;
    rem_o   = rem_i;
    emit_a  = 1'b0;
    kind_a  = pwfd_pkg::KIND_SCALAR;
    val_a   = 64'd0;
    last_a  = 1'b0;
    fail    = 1'b0;
    code    = pwfd_pkg::ERR_NONE;
    to_hdr  = 1'b0;

    case (state_i.phase)
      pwfd_pkg::PH_HEADER: begin
        state_o.acc   = acc_n;
        state_o.count = cnt_n;
        if (cont) begin
          state_o.cur_field = 32'd0;
          state_o.cur_wire  = 3'd0;
        end else begin
          state_o.cur_field = acc_n[34:3];
          state_o.cur_wire  = acc_n[2:0];
        end
        if (too_long) begin
          fail = 1'b1;
          code = pwfd_pkg::ERR_VARINT_LONG;
        end else if (cont) begin
          if (eob_i) begin
            fail = 1'b1;
            code = pwfd_pkg::ERR_TRUNCATED;
          end
        end else if (bad_wire) begin
          fail = 1'b1;
          code = pwfd_pkg::ERR_BAD_WIRE;
        end else if (eob_i) begin
          fail = 1'b1;
          code = pwfd_pkg::ERR_TRUNCATED;
        end else begin
          state_o.acc   = 64'd0;
          state_o.count = 4'd0;
          case (acc_n[2:0])
            pwfd_pkg::WIRE_VARINT:  state_o.phase = pwfd_pkg::PH_VARINT;
            pwfd_pkg::WIRE_FIXED64: state_o.phase = pwfd_pkg::PH_FIXED64;
            pwfd_pkg::WIRE_FIXED32: state_o.phase = pwfd_pkg::PH_FIXED32;
            default:                state_o.phase = pwfd_pkg::PH_LENGTH;
          endcase
        end
      end

      pwfd_pkg::PH_VARINT: begin
        state_o.acc   = acc_n;
        state_o.count = cnt_n;
        if (too_long) begin
          fail = 1'b1;
          code = pwfd_pkg::ERR_VARINT_LONG;
        end else if (!cont) begin
          emit_a = 1'b1;
          val_a  = acc_n;
          to_hdr = 1'b1;
        end else if (eob_i) begin
          fail = 1'b1;
          code = pwfd_pkg::ERR_TRUNCATED;
        end
      end

      pwfd_pkg::PH_FIXED32, pwfd_pkg::PH_FIXED64: begin
        state_o.acc   = acc_n;
        state_o.count = cnt_n;
        if (fixed_done) begin
          emit_a = 1'b1;
          val_a  = acc_n;
          to_hdr = 1'b1;
        end else if (eob_i) begin
          fail = 1'b1;
          code = pwfd_pkg::ERR_TRUNCATED;
        end
      end

      pwfd_pkg::PH_LENGTH: begin
        state_o.acc   = acc_n;
        state_o.count = cnt_n;
        if (too_long) begin
          fail = 1'b1;
          code = pwfd_pkg::ERR_VARINT_LONG;
        end else if (cont) begin
          if (eob_i) begin
            fail = 1'b1;
            code = pwfd_pkg::ERR_TRUNCATED;
          end
        end else if ((acc_n & ~LenMask) != 64'd0) begin
          fail = 1'b1;
          code = pwfd_pkg::ERR_LEN_WIDE;
        end else begin
          emit_a = 1'b1;
          kind_a = pwfd_pkg::KIND_LENGTH;
          val_a  = acc_n;
          if (acc_n == 64'd0) begin
            to_hdr = 1'b1;
          end else if (eob_i) begin
            fail = 1'b1;
            code = pwfd_pkg::ERR_TRUNCATED;
          end else begin
            rem_o         = acc_n[LENGTH_BITS-1:0];
            state_o.acc   = 64'd0;
            state_o.count = 4'd0;
            state_o.phase = pwfd_pkg::PH_PAYLOAD;
          end
        end
      end

      pwfd_pkg::PH_PAYLOAD: begin
        rem_o  = rem_n;
        emit_a = pass_i;
        kind_a = pwfd_pkg::KIND_PAYLOAD;
        val_a  = {56'd0, byte_i};
        last_a = (rem_n == '0);
        if (rem_n == '0) begin
          to_hdr = 1'b1;
        end else if (eob_i) begin
          fail = 1'b1;
          code = pwfd_pkg::ERR_TRUNCATED;
        end
      end

      pwfd_pkg::PH_ERROR: begin
        to_hdr = eob_i;
      end

      default: begin
        to_hdr = 1'b1;
      end
    endcase

    if (to_hdr) begin
      state_o.phase = pwfd_pkg::PH_HEADER;
      state_o.acc   = 64'd0;
      state_o.count = 4'd0;
    end
    // an error on the last buffer byte recovers at once
    if (fail) begin
      state_o.phase = eob_i ? pwfd_pkg::PH_HEADER : pwfd_pkg::PH_ERROR;
      state_o.acc   = 64'd0;
      state_o.count = 4'd0;
    end
  end

  pwfd_pkg::res_t res_a;
  pwfd_pkg::res_t res_e;

  always_comb begin
    res_a.kind         = kind_a;
    res_a.field_num    = state_o.cur_field;
    res_a.wire_kind    = state_o.cur_wire;
    res_a.value        = val_a;
    res_a.payload_last = last_a;
    res_a.error_code   = pwfd_pkg::ERR_NONE;

    res_e.kind         = pwfd_pkg::KIND_ERROR;
    res_e.field_num    = state_o.cur_field;
    res_e.wire_kind    = state_o.cur_wire;
    res_e.value        = 64'd0;
    res_e.payload_last = 1'b0;
    res_e.error_code   = code;

    res0_o    = emit_a ? res_a : res_e;
    res1_o    = res_e;
    res_cnt_o = {1'b0, emit_a} + {1'b0, fail};
  end

endmodule

FILE: src/pwfd_res_fifo.sv
// small result queue that takes up to two results per cycle
`timescale 1ns / 1ps

`include "protobuf_wire_field_decoder_core_defines.svh"

module pwfd_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     push_cnt_i,
  input  pwfd_pkg::res_t push0_i,
  input  pwfd_pkg::res_t push1_i,
  input  logic           pop_i,
  output logic           room_o,
  output logic           valid_o,
  output pwfd_pkg::res_t head_o
);

  localparam int PtrW = $clog2(pwfd_pkg::RES_DEPTH);
  localparam int CntW = PtrW + 1;

  pwfd_pkg::res_t mem_q [pwfd_pkg::RES_DEPTH];
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] count_after;
  logic            pop;

  assign valid_o     = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign pop         = pop_i && valid_o;
  assign count_after = count_q - CntW'(pop);
  // room for the worst case of two results from one byte
  assign room_o      = (count_after <= CntW'(pwfd_pkg::RES_DEPTH - 2));
  assign count_d     = count_after + CntW'(push_cnt_i);
  assign rd_ptr_d    = rd_ptr_q + PtrW'(pop);
  assign wr_ptr_d    = wr_ptr_q + PtrW'(push_cnt_i);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  `PWFD_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CntW'(pwfd_pkg::RES_DEPTH))
  `PWFD_ASSERT(a_ptr_gap, clk_i, rst_ni, wr_ptr_q == rd_ptr_q + count_q[PtrW-1:0])
  `PWFD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> count_q == '0)

endmodule

FILE: src/protobuf_wire_field_decoder_core.sv
// protobuf wire format field decoder, top level
//
//  channel   dir  handshake      payload
//  in_i      in   valid/ready    data_byte, end_of_buffer
//  out_o     out  valid/ready    kind, field_num, wire_kind, value,
//                                payload_last, error_code
//  cfg       in   cfg_we_i       cfg_data_i (pass_payload)
//
// one byte is taken per cycle while the result queue has room; a byte waits in the
// input register, then its results are queued and show on out_o in order
// a byte that ends the buffer in mid-field can give two results, which are
// queued together; in_i stalls while a byte waits in the input register and
// the four-entry result queue, after this cycle's pop, has fewer than two free entries
// reset clears the decode state to the header phase and pass_payload to 1
`timescale 1ns / 1ps

`include "protobuf_wire_field_decoder_core_defines.svh"

module protobuf_wire_field_decoder_core #(
  parameter int LENGTH_BITS = pwfd_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  pwfd_in_if.sink     in_i,
  pwfd_out_if.source  out_o
);

  logic                   pass_q;
  logic                   in_valid_q, in_valid_d;
  logic [7:0]             in_byte_q;
  logic                   in_eob_q;
  logic                   in_take;
  logic                   advance;
  logic                   room;
  pwfd_pkg::state_t       state_q, state_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  pwfd_pkg::res_t         res0;
  pwfd_pkg::res_t         res1;
  logic [1:0]             res_cnt;
  logic [1:0]             push_cnt;
  logic                   out_valid;
  pwfd_pkg::res_t         head;

  assign advance    = in_valid_q && room;
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;
  assign in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign push_cnt   = advance ? res_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q     <= 1'b1;
      in_valid_q <= 1'b0;
      state_q    <= '{phase: pwfd_pkg::PH_HEADER, acc: 64'd0, count: 4'd0,
                      cur_field: 32'd0, cur_wire: 3'd0};
      rem_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        pass_q <= cfg_data_i;
      end
      in_valid_q <= in_valid_d;
      if (advance) begin
        state_q <= state_d;
        rem_q   <= rem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_i.data_byte;
      in_eob_q  <= in_i.end_of_buffer;
    end
  end

  pwfd_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .pass_i   (pass_q),
    .byte_i   (in_byte_q),
    .eob_i    (in_eob_q),
    .state_i  (state_q),
    .rem_i    (rem_q),
    .state_o  (state_d),
    .rem_o    (rem_d),
    .res0_o   (res0),
    .res1_o   (res1),
    .res_cnt_o(res_cnt)
  );

  pwfd_res_fifo u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(push_cnt),
    .push0_i   (res0),
    .push1_i   (res1),
    .pop_i     (out_o.ready),
    .room_o    (room),
    .valid_o   (out_valid),
    .head_o    (head)
  );

  assign out_o.valid        = out_valid;
  assign out_o.kind         = head.kind;
  assign out_o.field_num    = head.field_num;
  assign out_o.wire_kind    = head.wire_kind;
  assign out_o.value        = head.value;
  assign out_o.payload_last = head.payload_last;
  assign out_o.error_code   = head.error_code;

  // the second result of one byte is always the error
  `PWFD_ASSERT(a_pair_ends_error, clk_i, rst_ni, push_cnt == 2'd2 |-> res1.kind == pwfd_pkg::KIND_ERROR)
  `PWFD_ASSERT(a_payload_left, clk_i, rst_ni, state_q.phase == pwfd_pkg::PH_PAYLOAD |-> rem_q != '0)
  `PWFD_ASSERT(a_stall_holds, clk_i, rst_ni, in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(in_eob_q))

endmodule

FILE: sim/tb_protobuf_wire_field_decoder_core.sv
// self-checking testbench for the protobuf wire field decoder core
`timescale 1ns / 1ps

module tb_protobuf_wire_field_decoder_core;

  localparam int          LEN_BITS   = pwfd_pkg::LENGTH_BITS_DEF;
  localparam int          WD_LIMIT   = 2000;
  localparam int          SETTLE     = 8;
  localparam int          MAX_VARINT = 10;
  localparam logic [2:0]  WIRE_SGROUP = 3'd3;
  localparam logic [2:0]  WIRE_EGROUP = 3'd4;
  localparam logic [2:0]  WIRE_RSVD6  = 3'd6;
  localparam logic [2:0]  WIRE_RSVD7  = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_data_i = 1'b0;

  pwfd_in_if  in_if ();
  pwfd_out_if out_if ();

  protobuf_wire_field_decoder_core #(
    .LENGTH_BITS(LEN_BITS)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // decoder mirror
  pwfd_pkg::phase_e dec_phase = pwfd_pkg::PH_HEADER;
  logic [63:0] dec_acc = '0;
  logic [3:0]  dec_count = '0;
  logic [63:0] dec_remaining = '0;
  logic [31:0] dec_field = '0;
  logic [2:0]  dec_wire = '0;
  bit          pass_payload = 1'b1;

  pwfd_pkg::res_t pending_fields[$];
  logic [7:0]  msg_q[$];

  bit idle_on = 1'b1;
  int mismatch_cnt = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int error_results = 0;
  int payload_results = 0;
  int quiet_cycles = 0;
  int stall_left = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int take_varint(logic [7:0] b);
    int sh;
    sh = 7 * dec_count;
    if (sh < 64) dec_acc |= {57'd0, b[6:0]} << sh;
    dec_count = dec_count + 4'd1;
    if (!b[7]) return 1;
    return (dec_count >= MAX_VARINT) ? 2 : 0;
  endfunction

  task automatic enter_phase(pwfd_pkg::phase_e p);
    dec_phase = p;
    dec_acc = '0;
    dec_count = '0;
  endtask

  task automatic push_field(pwfd_pkg::kind_e k, logic [63:0] v, bit last, pwfd_pkg::err_e e);
    pwfd_pkg::res_t r;
    r.kind = k;
    r.field_num = dec_field;
    r.wire_kind = dec_wire;
    r.value = v;
    r.payload_last = last;
    r.error_code = e;
    pending_fields.push_back(r);
  endtask

  task automatic raise_error(pwfd_pkg::err_e e, bit eob);
    push_field(pwfd_pkg::KIND_ERROR, '0, 1'b0, e);
    if (eob) enter_phase(pwfd_pkg::PH_HEADER);
    else dec_phase = pwfd_pkg::PH_ERROR;
  endtask

  task automatic decode_byte(logic [7:0] b, bit eob);
    int r;
    int total;
    case (dec_phase)
      pwfd_pkg::PH_HEADER: begin
        if (dec_count == 0) begin
          dec_field = '0;
          dec_wire = '0;
        end
        r = take_varint(b);
        if (r == 2) raise_error(pwfd_pkg::ERR_VARINT_LONG, eob);
        else if (r == 0) begin
          if (eob) raise_error(pwfd_pkg::ERR_TRUNCATED, eob);
        end else begin
          dec_field = dec_acc[34:3];
          dec_wire = dec_acc[2:0];
          if (!(dec_wire inside {pwfd_pkg::WIRE_VARINT, pwfd_pkg::WIRE_FIXED64,
                                 pwfd_pkg::WIRE_LEN, pwfd_pkg::WIRE_FIXED32}))
            raise_error(pwfd_pkg::ERR_BAD_WIRE, eob);
          else if (eob) raise_error(pwfd_pkg::ERR_TRUNCATED, eob);
          else if (dec_wire == pwfd_pkg::WIRE_VARINT) enter_phase(pwfd_pkg::PH_VARINT);
          else if (dec_wire == pwfd_pkg::WIRE_FIXED64) enter_phase(pwfd_pkg::PH_FIXED64);
          else if (dec_wire == pwfd_pkg::WIRE_FIXED32) enter_phase(pwfd_pkg::PH_FIXED32);
          else enter_phase(pwfd_pkg::PH_LENGTH);
        end
      end
      pwfd_pkg::PH_VARINT: begin
        r = take_varint(b);
        if (r == 2) raise_error(pwfd_pkg::ERR_VARINT_LONG, eob);
        else if (r == 1) begin
          push_field(pwfd_pkg::KIND_SCALAR, dec_acc, 1'b0, pwfd_pkg::ERR_NONE);
          enter_phase(pwfd_pkg::PH_HEADER);
        end else if (eob) raise_error(pwfd_pkg::ERR_TRUNCATED, eob);
      end
      pwfd_pkg::PH_FIXED32, pwfd_pkg::PH_FIXED64: begin
        total = (dec_phase == pwfd_pkg::PH_FIXED32) ? 4 : 8;
        dec_acc |= {56'd0, b} << (8 * dec_count[2:0]);
        dec_count = dec_count + 4'd1;
        if (dec_count >= total) begin
          push_field(pwfd_pkg::KIND_SCALAR, dec_acc, 1'b0, pwfd_pkg::ERR_NONE);
          enter_phase(pwfd_pkg::PH_HEADER);
        end else if (eob) raise_error(pwfd_pkg::ERR_TRUNCATED, eob);
      end
      pwfd_pkg::PH_LENGTH: begin
        r = take_varint(b);
        if (r == 2) raise_error(pwfd_pkg::ERR_VARINT_LONG, eob);
        else if (r == 0) begin
          if (eob) raise_error(pwfd_pkg::ERR_TRUNCATED, eob);
        end else if ((dec_acc >> LEN_BITS) != 0) raise_error(pwfd_pkg::ERR_LEN_WIDE, eob);
        else begin
          push_field(pwfd_pkg::KIND_LENGTH, dec_acc, 1'b0, pwfd_pkg::ERR_NONE);
          if (dec_acc == 0) enter_phase(pwfd_pkg::PH_HEADER);
          else if (eob) raise_error(pwfd_pkg::ERR_TRUNCATED, eob);
          else begin
            dec_remaining = dec_acc;
            enter_phase(pwfd_pkg::PH_PAYLOAD);
          end
        end
      end
      pwfd_pkg::PH_PAYLOAD: begin
        dec_remaining = dec_remaining - 64'd1;
        if (pass_payload)
          push_field(pwfd_pkg::KIND_PAYLOAD, {56'd0, b}, dec_remaining == 0,
                     pwfd_pkg::ERR_NONE);
        if (dec_remaining == 0) enter_phase(pwfd_pkg::PH_HEADER);
        else if (eob) raise_error(pwfd_pkg::ERR_TRUNCATED, eob);
      end
      default: begin
        if (eob) enter_phase(pwfd_pkg::PH_HEADER);
      end
    endcase
  endtask

  // one request; called and returns right after a rising edge
  task automatic send_byte(logic [7:0] b, bit eob);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.end_of_buffer <= eob;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_byte(b, eob);
    bytes_sent++;
  endtask

  // sends the first n buffered bytes, end of buffer on the last one
  task automatic send_buffer(int n);
    for (int i = 0; i < n; i++) send_byte(msg_q[i], i == n - 1);
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk_i);
    // bytes that give no result may still sit in the pipeline
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_pass_payload(bit v);
    wait_results_drained();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pass_payload = v;
  endtask

  task automatic add_varint(logic [63:0] v, int pad);
    logic [63:0] x;
    int n;
    x = v >> 7;
    n = 1;
    while (x != 0) begin
      n++;
      x = x >> 7;
    end
    n = (n + pad > MAX_VARINT) ? MAX_VARINT : n + pad;
    x = v;
    for (int i = 0; i < n; i++) begin
      msg_q.push_back({i < n - 1, x[6:0]});
      x = x >> 7;
    end
  endtask

  task automatic add_overlong();
    repeat (MAX_VARINT) msg_q.push_back(8'h80 | 8'($urandom));
  endtask

  task automatic add_field();
    logic [63:0] fnum;
    logic [63:0] v;
    logic [2:0]  w;
    int sel;
    int pad;
    int len;
    int vw;
    sel = $urandom_range(0, 19);
    if (sel < 5) w = pwfd_pkg::WIRE_VARINT;
    else if (sel < 8) w = pwfd_pkg::WIRE_FIXED64;
    else if (sel < 11) w = pwfd_pkg::WIRE_FIXED32;
    else if (sel < 18) w = pwfd_pkg::WIRE_LEN;
    else if (sel == 18) w = $urandom_range(0, 1) ? WIRE_SGROUP : WIRE_EGROUP;
    else w = $urandom_range(0, 1) ? WIRE_RSVD6 : WIRE_RSVD7;
    sel = $urandom_range(0, 9);
    if (sel < 6) fnum = $urandom_range(0, 31);
    else if (sel < 9) fnum = $urandom;
    else fnum = rand64() >> 3;
    pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0;
    if ($urandom_range(0, 39) == 0) begin
      add_overlong();
      return;
    end
    add_varint((fnum << 3) | w, pad);
    case (w)
      pwfd_pkg::WIRE_VARINT: begin
        sel = $urandom_range(0, 19);
        if (sel == 0) add_overlong();
        else if (sel == 1) begin
          // ten bytes that end cleanly; high bits of the last one fall off
          repeat (MAX_VARINT - 1) msg_q.push_back(8'h80 | 8'($urandom));
          msg_q.push_back(8'($urandom) & 8'h7F);
        end else begin
          v = rand64();
          vw = $urandom_range(0, 64);
          if (vw < 64) v = v & ((64'd1 << vw) - 64'd1);
          add_varint(v, pad);
        end
      end
      pwfd_pkg::WIRE_FIXED64: repeat (8) msg_q.push_back(8'($urandom));
      pwfd_pkg::WIRE_FIXED32: repeat (4) msg_q.push_back(8'($urandom));
      pwfd_pkg::WIRE_LEN: begin
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          add_varint(rand64() | (64'd1 << $urandom_range(LEN_BITS, 63)), 0);
          msg_q.push_back(8'($urandom));
        end else if (sel == 1) add_overlong();
        else begin
          len = (sel == 2) ? $urandom_range(7, 40) : $urandom_range(0, 6);
          add_varint(len, pad);
          repeat (len) msg_q.push_back(8'($urandom));
        end
      end
      default: repeat ($urandom_range(0, 2)) msg_q.push_back(8'($urandom));
    endcase
  endtask

  task automatic send_message();
    int n;
    msg_q.delete();
    repeat ($urandom_range(1, 4)) add_field();
    n = msg_q.size();
    if ($urandom_range(0, 6) == 0) n = $urandom_range(1, n);
    send_buffer(n);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom),
                (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0));
  endtask

  task automatic run_random(int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 9) < 8) send_message();
      else send_noise();
    end
  endtask

  // zero varint, all-ones fixed32 and fixed64, zero length, one payload byte
  task automatic test_value_kinds();
    msg_q = '{8'h08, 8'h00,
              8'h0D, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'h11, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'h12, 8'h00,
              8'h1A, 8'h01, 8'hAB};
    send_buffer(msg_q.size());
  endtask

  task automatic test_error_cases();
    // bad wire type, then two bytes that are dropped up to the end of the buffer
    msg_q = '{8'h0B, 8'h55, 8'h00};
    send_buffer(msg_q.size());
    // overlong tag whose tenth byte also ends the buffer
    msg_q.delete();
    repeat (MAX_VARINT) msg_q.push_back(8'h80);
    send_buffer(msg_q.size());
    // length of 2^32
    msg_q = '{8'h12, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
    send_buffer(msg_q.size());
    // tag cut off, tag complete on the last byte, payload cut off after its length
    msg_q = '{8'h80};
    send_buffer(1);
    msg_q = '{8'h08};
    send_buffer(1);
    msg_q = '{8'h12, 8'h02};
    send_buffer(2);
  endtask

  task automatic test_payload_pass();
    run_random(350);
  endtask

  task automatic test_payload_skip();
    write_pass_payload(1'b0);
    run_random(350);
  endtask

  task automatic test_payload_restore();
    write_pass_payload(1'b1);
    run_random(350);
  endtask

  task automatic test_back_to_back();
    write_pass_payload(1'b0);
    idle_on = 1'b0;
    run_random(350);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 20)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    pwfd_pkg::res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (out_if.kind == pwfd_pkg::KIND_ERROR) error_results++;
      if (out_if.kind == pwfd_pkg::KIND_PAYLOAD) payload_results++;
      if (pending_fields.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 20)
          $display("%0t: unexpected result, expected none, actual kind %0d value %0h",
                   $time, out_if.kind, out_if.value);
      end else begin
        want = pending_fields.pop_front();
        check_field("kind", want.kind, out_if.kind);
        check_field("field_num", want.field_num, out_if.field_num);
        check_field("wire_kind", want.wire_kind, out_if.wire_kind);
        check_field("value", want.value, out_if.value);
        check_field("payload_last", want.payload_last, out_if.payload_last);
        check_field("error_code", want.error_code, out_if.error_code);
      end
    end
  end

  // output stalls in bursts
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WD_LIMIT) begin
          $display("%0t: no request or result moved for %0d cycles", $time, WD_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.end_of_buffer = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_value_kinds();
    test_error_cases();
    test_payload_pass();
    test_payload_skip();
    test_payload_restore();
    test_back_to_back();

    wait_results_drained();
    repeat (SETTLE) @(posedge clk_i);

    $display("decoded %0d bytes with payload passing on and off, stalls and back-to-back",
             bytes_sent);
    $display("checked %0d results: %0d errors, %0d payload bytes",
             results_seen, error_results, payload_results);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/pwfd_pkg.sv
src/pwfd_if.sv
src/pwfd_step.sv
src/pwfd_res_fifo.sv
src/protobuf_wire_field_decoder_core.sv
sim/tb_protobuf_wire_field_decoder_core.sv
